// File: hw/rtl/pch_pkg.sv
package pch_pkg;

  // Default palette depth
  localparam int PCH_ENTRIES_DEF = 256;

  // Field widths
  localparam int IDX_W      = 8;
  localparam int VAL_W      = 32;
  localparam int HASH_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int RGB_W      = 24;

  // Hash rotation amount
  localparam int ROT_L = 5;

  localparam logic [VAL_W-1:0] RGB_MASK   = 32'h00ff_ffff;
  localparam logic [VAL_W-1:0] ALPHA_MASK = 32'hff00_0000;

  // Item kinds carried in the input tuser bit
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_APPLY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_EN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_ONLY = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_wr;     // write zero at the sweep address
    logic wr_item;    // write item accepted this cycle
    logic rd_issue;   // read palette at the sweep address for the walk
    logic hash_clr;   // start a new hash
    logic walk_done;  // walk finished, clear dirty flag
    logic out_load;   // load the output word
  } pch_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic dirty;
  } pch_sts_t;

endpackage

// File: hw/rtl/pch_dpath.sv
module pch_dpath #(
  parameter int PALETTE_ENTRIES = pch_pkg::PCH_ENTRIES_DEF,
  parameter int AW              = $clog2(PALETTE_ENTRIES)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pch_pkg::pch_cmd_t               cmd,
  output pch_pkg::pch_sts_t               sts,
  input  logic [AW-1:0]                   cnt,
  input  logic [pch_pkg::IDX_W-1:0]       item_idx,
  input  logic [pch_pkg::VAL_W-1:0]       item_val,
  input  logic                            cfg_we,
  input  logic [pch_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pch_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [pch_pkg::HASH_W-1:0]      out_hash
);
  import pch_pkg::*;

  localparam int IW = (AW > IDX_W) ? AW : IDX_W;

  logic [VAL_W-1:0]  mem [PALETTE_ENTRIES];

  logic              key_en_r,     key_en_nxt;
  logic [RGB_W-1:0]  key_color_r,  key_color_nxt;
  logic              alpha_only_r, alpha_only_nxt;
  logic              dirty_r,      dirty_nxt;
  logic [HASH_W-1:0] hash_r,       hash_nxt;
  logic              wb_vld_r;
  logic [AW-1:0]     wb_addr_r;
  logic [VAL_W-1:0]  rd_data_r;
  logic [HASH_W-1:0] out_hash_r;

  logic              item_in_range;
  logic [IW-1:0]     idx_ext;
  logic [AW-1:0]     item_addr;
  logic              key_match;
  logic [VAL_W-1:0]  keyed;
  logic [HASH_W-1:0] hash_add;
  logic              we;
  logic [AW-1:0]     wa;
  logic [VAL_W-1:0]  wd;

  assign idx_ext       = IW'(item_idx);
  assign item_addr     = idx_ext[AW-1:0];
  assign item_in_range = (32'(item_idx) < PALETTE_ENTRIES);

  // Key the entry coming back from the walk read
  assign key_match = key_en_r && (rd_data_r[RGB_W-1:0] == key_color_r);
  assign keyed     = key_match ? (rd_data_r & RGB_MASK) : (rd_data_r | ALPHA_MASK);
  assign hash_add  = alpha_only_r ? (keyed & ALPHA_MASK) : keyed;

  always_comb begin
    we = 1'b0;
    wa = cnt;
    wd = '0;
    if (cmd.clr_wr) begin
      we = 1'b1;
    end else if (wb_vld_r) begin
      we = 1'b1;
      wa = wb_addr_r;
      wd = keyed;
    end else if (cmd.wr_item && item_in_range) begin
      we = 1'b1;
      wa = item_addr;
      wd = item_val;
    end
  end

  always_comb begin
    key_en_nxt     = key_en_r;
    key_color_nxt  = key_color_r;
    alpha_only_nxt = alpha_only_r;
    dirty_nxt      = dirty_r;
    hash_nxt       = hash_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_EN: begin
          key_en_nxt = cfg_data[0];
          dirty_nxt  = 1'b1;
        end
        CFG_KEY_COLOR: begin
          key_color_nxt = cfg_data[RGB_W-1:0];
          dirty_nxt     = 1'b1;
        end
        CFG_ALPHA_ONLY: begin
          alpha_only_nxt = cfg_data[0];
          dirty_nxt      = 1'b1;
        end
        default: ;
      endcase
    end
    if (cmd.wr_item && item_in_range) begin
      dirty_nxt = 1'b1;
    end
    if (cmd.walk_done) begin
      dirty_nxt = 1'b0;
    end
    if (cmd.hash_clr) begin
      hash_nxt = '0;
    end else if (wb_vld_r) begin
      hash_nxt = ((hash_r << ROT_L) | (hash_r >> (HASH_W - ROT_L))) + hash_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_en_r     <= 1'b0;
      key_color_r  <= '0;
      alpha_only_r <= 1'b0;
      dirty_r      <= 1'b1;
      hash_r       <= '0;
      wb_vld_r     <= 1'b0;
    end else begin
      key_en_r     <= key_en_nxt;
      key_color_r  <= key_color_nxt;
      alpha_only_r <= alpha_only_nxt;
      dirty_r      <= dirty_nxt;
      hash_r       <= hash_nxt;
      wb_vld_r     <= cmd.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= cnt;
    rd_data_r <= mem[cnt];
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.out_load) begin
      out_hash_r <= hash_r;
    end
  end

  assign sts.dirty = dirty_r;
  assign out_hash  = out_hash_r;

endmodule

// File: hw/rtl/pch_ctrl.sv
module pch_ctrl #(
  parameter int PALETTE_ENTRIES = pch_pkg::PCH_ENTRIES_DEF,
  parameter int AW              = $clog2(PALETTE_ENTRIES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_action,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic              out_rec,
  output pch_pkg::pch_cmd_t cmd,
  input  pch_pkg::pch_sts_t sts,
  output logic [AW-1:0]     cnt
);
  import pch_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(PALETTE_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_POST
  } state_t;

  state_t        state_r,  state_nxt;
  logic [AW-1:0] cnt_r,    cnt_nxt;
  logic          ovld_r,   ovld_nxt;
  logic          orec_r,   orec_nxt;
  logic          rec_r,    rec_nxt;
  logic          slot_free;
  logic          accept;

  assign slot_free = !ovld_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rec_nxt   = rec_r;
    orec_nxt  = orec_r;
    ovld_nxt  = ovld_r && !out_tready;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_action == ACT_WRITE) begin
            cmd.wr_item = 1'b1;
          end else if (sts.dirty) begin
            cmd.hash_clr = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = ST_WALK;
          end else if (slot_free) begin
            cmd.out_load = 1'b1;
            ovld_nxt     = 1'b1;
            orec_nxt     = 1'b0;
          end else begin
            rec_nxt   = 1'b0;
            state_nxt = ST_POST;
          end
        end
      end
      ST_WALK: begin
        cmd.rd_issue = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // last entry is keyed and hashed in this cycle
        cmd.walk_done = 1'b1;
        rec_nxt       = 1'b1;
        state_nxt     = ST_POST;
      end
      ST_POST: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          ovld_nxt     = 1'b1;
          orec_nxt     = rec_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
      orec_r  <= 1'b0;
      rec_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
      orec_r  <= orec_nxt;
      rec_r   <= rec_nxt;
    end
  end

  assign cnt        = cnt_r;
  assign out_tvalid = ovld_r;
  assign out_rec    = orec_r;

endmodule

// File: hw/rtl/palette_chroma_key_hasher.sv
// Palette chroma-key hasher. Holds a palette of PALETTE_ENTRIES 32-bit ARGB
// words in one on-chip memory, plus a dirty flag and a 32-bit hash. A write
// word (in_tuser = 0) stores one entry and marks the palette dirty; slots at
// or past PALETTE_ENTRIES are dropped. An apply word (in_tuser = 1) on a
// clean palette returns the stored hash with out_tuser = 0. On a dirty
// palette it walks every entry, one per cycle through the memory read port:
// entries whose RGB matches the key color (with keying on) get alpha 0x00,
// all others alpha 0xff, each is written back, and the hash is rotated left
// by 5 and added to. The result word then appears with out_tuser = 1. One
// item is in work at a time; a write word is taken while a result still
// waits on the output. After reset a clearing pass zeroes the palette;
// in_tready stays low during it, while configuration writes are taken at any
// time. Any configuration write to a defined register marks the palette
// dirty.
module palette_chroma_key_hasher #(
  parameter int PALETTE_ENTRIES = pch_pkg::PCH_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [39:0]                     in_tdata,   // entry_index[7:0], entry_value[39:8]
  input  logic                            in_tuser,   // action
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pch_pkg::HASH_W-1:0]      out_tdata,  // palette_hash[31:0]
  output logic                            out_tuser,  // recomputed
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pch_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pch_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pch_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);

  pch_cmd_t      cmd;
  pch_sts_t      sts;
  logic [AW-1:0] cnt;

  // Registers take a write word in any cycle
  assign cfg_ready = 1'b1;

  pch_ctrl #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .AW              (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_action  (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_rec    (out_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .cnt        (cnt)
  );

  pch_dpath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .AW              (AW)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cnt       (cnt),
    .item_idx  (in_tdata[IDX_W-1:0]),
    .item_val  (in_tdata[IDX_W+VAL_W-1:IDX_W]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_hash  (out_tdata)
  );

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import pch_pkg::*;

  localparam int PAL_N = PCH_ENTRIES_DEF;
  // Register index past the defined list: the block must drop it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // Receiver hold-off used to back the block up into its input
  localparam int LONG_HOLD = 600;
  localparam int SEG_ITEMS = 105;
  localparam int DIR_ROWS = 24;

  // One result word: hash plus the "walked the palette now" flag
  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic              recomp;
  } hash_result_t;

  typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

  // Directed row: either a stream word or a register write (data in val)
  typedef struct packed {
    row_kind_t            kind;
    logic                 act;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [IDX_W-1:0]     idx;
    logic [VAL_W-1:0]     val;
    logic                 typed;
    hash_result_t         res;
  } stim_row_t;

  localparam hash_result_t NO_RES     = '0;
  localparam hash_result_t ZERO_FRESH = '{hash: '0, recomp: 1'b1};
  localparam hash_result_t ZERO_STALE = '{hash: '0, recomp: 1'b0};

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [39:0]           in_tdata   = '0;   // entry_index[7:0], entry_value[39:8]
  logic                  in_tuser   = 1'b0; // action
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [HASH_W-1:0]     out_tdata;         // palette_hash[31:0]
  logic                  out_tuser;         // recomputed
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Mirror of the block's state and registers
  logic [VAL_W-1:0]  pal_mirror [PAL_N];
  logic              dirty_m;
  logic [HASH_W-1:0] hash_m;
  logic              key_en_m;
  logic [RGB_W-1:0]  key_color_m;
  logic              alpha_only_m;

  // Hash results still owed by the block, oldest first
  hash_result_t hash_expect_q [$];

  int err_cnt       = 0;
  int n_writes      = 0;
  int n_applies     = 0;
  int n_rekeyed     = 0;
  int n_reg_writes  = 0;
  int send_idle_pct = 12;
  int recv_idle_pct = 70;
  int hold_asks     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  stim_row_t dir_tab [DIR_ROWS];

  palette_chroma_key_hasher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Walk the whole mirror: key each entry, write it back, fold it into the hash
  function automatic void rekey_palette();
    logic [HASH_W-1:0] h;
    logic [VAL_W-1:0]  e;
    h = '0;
    for (int i = 0; i < PAL_N; i++) begin
      e = pal_mirror[i];
      if (key_en_m && ((e & RGB_MASK) == {8'h00, key_color_m}))
        e = e & RGB_MASK;
      else
        e = e | ALPHA_MASK;
      pal_mirror[i] = e;
      h = (h << ROT_L) | (h >> (HASH_W - ROT_L));
      h = h + (alpha_only_m ? (e & ALPHA_MASK) : e);
    end
    hash_m  = h;
    dirty_m = 1'b0;
  endfunction

  // Offer one stream word after a random gap, hold it until taken, then
  // update the mirror. A typed row overrides the predicted result.
  task automatic push_word(input logic act, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val, input logic typed,
                           input hash_result_t fixed_res);
    hash_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {val, idx};
    do @(posedge clk); while (!in_tready);
    if (act == ACT_WRITE) begin
      pal_mirror[idx] = val;
      dirty_m = 1'b1;
      n_writes++;
    end else begin
      r.recomp = dirty_m;
      if (dirty_m) begin
        rekey_palette();
        n_rekeyed++;
      end
      r.hash = hash_m;
      hash_expect_q.push_back(typed ? fixed_res : r);
      n_applies++;
    end
  endtask

  // Write one register; drop valid and step the clock with it low so back-to-back
  // writes never lower and raise valid in the same step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_KEY_EN: begin
        key_en_m = data[0];
        dirty_m  = 1'b1;
      end
      CFG_KEY_COLOR: begin
        key_color_m = data[RGB_W-1:0];
        dirty_m     = 1'b1;
      end
      CFG_ALPHA_ONLY: begin
        alpha_only_m = data[0];
        dirty_m      = 1'b1;
      end
      default: ;
    endcase
    n_reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering words, wait out every owed result, then let a trailing
  // palette write settle before the caller touches registers.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (hash_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One random configuration followed by a run of random words
  task automatic run_segment(input int n);
    int               r;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic [7:0]       alpha;
    logic [CFG_DATA_W-1:0] data;
    wait_idle();
    data = CFG_DATA_W'($urandom);
    write_reg(CFG_KEY_EN, data);
    case ($urandom_range(3))
      0:       data = '0;
      1:       data = '1;
      default: data = CFG_DATA_W'($urandom);
    endcase
    write_reg(CFG_KEY_COLOR, data);
    data = CFG_DATA_W'($urandom);
    write_reg(CFG_ALPHA_ONLY, data);
    if ($urandom_range(3) == 0) begin
      data = CFG_DATA_W'($urandom);
      write_reg(CFG_UNUSED, data);
    end
    repeat (n) begin
      r     = $urandom_range(99);
      idx   = IDX_W'($urandom);
      val   = $urandom;
      alpha = 8'($urandom);
      if (r < 18) begin
        // Index and value bits on an apply word are noise
        push_word(ACT_APPLY, idx, val, 1'b0, NO_RES);
      end else begin
        case ($urandom_range(5))
          0:       idx = '0;
          1:       idx = '1;
          default: ;
        endcase
        // Bias values toward the key color so keying actually triggers
        case ($urandom_range(4))
          0, 1:    val = {alpha, key_color_m};
          2:       val = $urandom_range(1) ? 32'hffff_ffff : 32'h0000_0000;
          default: ;
        endcase
        push_word(ACT_WRITE, idx, val, 1'b0, NO_RES);
      end
    end
  endtask

  // Receiver: random stalls, or a long hold-off when the stimulus asks
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result word against the oldest owed result
  always @(posedge clk) begin
    hash_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (hash_expect_q.size() == 0) begin
        $error("unexpected result word: palette_hash %08h, recomputed %0b",
               out_tdata, out_tuser);
        err_cnt++;
      end else begin
        want = hash_expect_q.pop_front();
        if (out_tdata !== want.hash) begin
          $error("palette_hash: expected %08h, actual %08h", want.hash, out_tdata);
          err_cnt++;
        end
        if (out_tuser !== want.recomp) begin
          $error("recomputed: expected %0b, actual %0b", want.recomp, out_tuser);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    // Mirror starts in the reset state
    foreach (pal_mirror[i]) pal_mirror[i] = '0;
    dirty_m      = 1'b1;
    hash_m       = '0;
    key_en_m     = 1'b0;
    key_color_m  = '0;
    alpha_only_m = 1'b0;

    // Directed rows. With keying on and key color zero, the cleared
    // palette keys every entry to zero, so the first hash is zero.
    dir_tab = '{
      '{ROW_REG,  ACT_WRITE, CFG_KEY_EN,     8'd0,   32'h00ff_ffff, 1'b0, NO_RES},
      '{ROW_REG,  ACT_WRITE, CFG_KEY_COLOR,  8'd0,   32'h0000_0000, 1'b0, NO_RES},
      '{ROW_ITEM, ACT_APPLY, CFG_KEY_EN,     8'd0,   32'h0000_0000, 1'b1, ZERO_FRESH},
      '{ROW_ITEM, ACT_APPLY, CFG_KEY_EN,     8'd0,   32'hffff_ffff, 1'b1, ZERO_STALE},
      // undefined register index: palette must stay clean
      '{ROW_REG,  ACT_WRITE, CFG_UNUSED,     8'd0,   32'h00ff_ffff, 1'b0, NO_RES},
      '{ROW_ITEM, ACT_APPLY, CFG_KEY_EN,     8'd255, 32'h0000_0000, 1'b1, ZERO_STALE},
      '{ROW_ITEM, ACT_WRITE, CFG_KEY_EN,     8'd0,   32'hffff_ffff, 1'b0, NO_RES},
      '{ROW_ITEM, ACT_WRITE, CFG_KEY_EN,     8'd1,   32'hff00_0000, 1'b0, NO_RES},
      '{ROW_ITEM, ACT_WRITE, CFG_KEY_EN,     8'd255, 32'h0000_0000, 1'b0, NO_RES},
      '{ROW_ITEM, ACT_WRITE, CFG_KEY_EN,     8'd128, 32'h1234_5678, 1'b0, NO_RES},
      '{ROW_ITEM, ACT_WRITE, CFG_KEY_EN,     8'd127, 32'h00ff_ffff, 1'b0, NO_RES},
      '{ROW_ITEM, ACT_APPLY, CFG_KEY_EN,     8'd0,   32'h0000_0000, 1'b0, NO_RES},
      '{ROW_ITEM, ACT_APPLY, CFG_KEY_EN,     8'd0,   32'h0000_0000, 1'b0, NO_RES},
      '{ROW_REG,  ACT_WRITE, CFG_ALPHA_ONLY, 8'd0,   32'h00ff_ffff, 1'b0, NO_RES},
      '{ROW_ITEM, ACT_APPLY, CFG_KEY_EN,     8'd0,   32'h0000_0000, 1'b0, NO_RES},
      '{ROW_ITEM, ACT_WRITE, CFG_KEY_EN,     8'd127, 32'hffff_ffff, 1'b0, NO_RES},
      '{ROW_REG,  ACT_WRITE, CFG_KEY_COLOR,  8'd0,   32'h00ff_ffff, 1'b0, NO_RES},
      '{ROW_ITEM, ACT_APPLY, CFG_KEY_EN,     8'd0,   32'h0000_0000, 1'b0, NO_RES},
      // bit 0 clear with all upper bits set: keying turns off
      '{ROW_REG,  ACT_WRITE, CFG_KEY_EN,     8'd0,   32'h00ff_fffe, 1'b0, NO_RES},
      '{ROW_ITEM, ACT_APPLY, CFG_KEY_EN,     8'd0,   32'h0000_0000, 1'b0, NO_RES},
      '{ROW_REG,  ACT_WRITE, CFG_ALPHA_ONLY, 8'd0,   32'h0000_0000, 1'b0, NO_RES},
      '{ROW_ITEM, ACT_WRITE, CFG_KEY_EN,     8'd64,  32'h8080_8080, 1'b0, NO_RES},
      '{ROW_ITEM, ACT_APPLY, CFG_KEY_EN,     8'd0,   32'h0000_0000, 1'b0, NO_RES},
      '{ROW_ITEM, ACT_APPLY, CFG_KEY_EN,     8'd0,   32'h0000_0000, 1'b0, NO_RES}
    };

    // Hold reset, then release once; the clearing pass is covered by in_tready
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].val[CFG_DATA_W-1:0]);
      end else begin
        push_word(dir_tab[i].act, dir_tab[i].idx, dir_tab[i].val,
                  dir_tab[i].typed, dir_tab[i].res);
      end
    end

    // Back-pressure: hold the receiver off while offering applies and writes,
    // so a result sits on the output and the next apply stalls the input
    wait_idle();
    hold_asks++;
    repeat (4) begin
      push_word(ACT_WRITE, IDX_W'($urandom), $urandom, 1'b0, NO_RES);
      push_word(ACT_APPLY, IDX_W'($urandom), $urandom, 1'b0, NO_RES);
    end
    // Pause the sender until every owed result has drained
    wait_idle();

    // Random phases: sender-light, receiver-light, then no idling at all
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (4) run_segment(SEG_ITEMS);
    end

    // Drain, then watch for stray words for about one palette walk
    wait_idle();
    repeat (PAL_N + 8) @(posedge clk);

    $display("Ran %0d palette writes and %0d apply words (%0d full rekey walks),",
             n_writes, n_applies, n_rekeyed);
    $display("with %0d register writes across keying and alpha-only hash settings.",
             n_reg_writes);
    if (err_cnt == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
